// ===== hdl/owp_pkg.sv =====
// shared types and constants for the omni wheel speed controller
`timescale 1ns / 1ps
`default_nettype none

package owp_pkg;

    localparam int NWHEEL  = 3;
    localparam int IN_W    = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 32;
    localparam int FRAC_W  = 15;
    localparam int TGT_W   = SUM_W - FRAC_W;
    localparam int ERR_W   = 18;
    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 32;
    localparam int DUTY_W  = 13;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic signed [IN_W-1:0] C866 = 16'sd28378;
    localparam logic signed [IN_W-1:0] R012 = 16'sd3932;
    localparam int HALF_SH = 14;
    localparam int ONE_SH  = 15;

    localparam logic [DUTY_W-1:0] FULL_SCALE = 13'd7200;
    localparam logic [DUTY_W-1:0] LIM_RESET  = 13'd7100;

    localparam logic [IDX_W-1:0] CFG_KP  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_KI  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LIM = 2'd2;

    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic [DUTY_W-1:0] t_duty;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KMUL,
        ST_KSUM,
        ST_ERR,
        ST_PMUL,
        ST_ACC,
        ST_DRV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic sum_en;
        logic err_en;
    } t_kin_ctrl;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic drv_en;
    } t_lane_ctrl;

endpackage

`default_nettype wire

// ===== hdl/owp_kin.sv =====
// body velocity to wheel target and per wheel speed error
`timescale 1ns / 1ps
`default_nettype none

module owp_kin (
    input  wire                              i_clk,
    input  owp_pkg::t_kin_ctrl               i_ctrl,
    input  wire signed [owp_pkg::IN_W-1:0]   i_vx,
    input  wire signed [owp_pkg::IN_W-1:0]   i_vy,
    input  wire signed [owp_pkg::IN_W-1:0]   i_w,
    input  wire signed [owp_pkg::IN_W-1:0]   i_enc_a,
    input  wire signed [owp_pkg::IN_W-1:0]   i_enc_b,
    input  wire signed [owp_pkg::IN_W-1:0]   i_enc_c,
    output owp_pkg::t_err                    o_err [owp_pkg::NWHEEL]
);
    import owp_pkg::*;

    logic signed [IN_W-1:0]   r_vx, r_vy, r_w;
    logic signed [IN_W-1:0]   r_enc [NWHEEL];
    logic signed [PROD_W-1:0] r_px, r_rw;
    logic signed [SUM_W-1:0]  r_sum [NWHEEL];
    t_err                     r_err [NWHEEL];

    logic signed [SUM_W-1:0]  w_half, w_full;
    t_err                     n_err [NWHEEL];

    assign w_half = SUM_W'(r_vy) <<< HALF_SH;
    assign w_full = SUM_W'(r_vy) <<< ONE_SH;

    // truncate toward zero, then subtract the measured speed
    always_comb begin
        logic signed [TGT_W-1:0] q;
        logic                    up;
        for (int j = 0; j < NWHEEL; j++) begin
            up = r_sum[j][SUM_W-1] && (r_sum[j][FRAC_W-1:0] != '0);
            q  = $signed(r_sum[j][SUM_W-1:FRAC_W]) + $signed({{(TGT_W-1){1'b0}}, up});
            n_err[j] = ERR_W'(q) - ERR_W'(r_enc[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_vx     <= i_vx;
            r_vy     <= i_vy;
            r_w      <= i_w;
            r_enc[0] <= i_enc_a;
            r_enc[1] <= i_enc_b;
            r_enc[2] <= i_enc_c;
        end
        if (i_ctrl.mul_en) begin
            r_px <= PROD_W'(C866) * PROD_W'(r_vx);
            r_rw <= PROD_W'(R012) * PROD_W'(r_w);
        end
        if (i_ctrl.sum_en) begin
            r_sum[0] <= r_px + w_half + r_rw;
            r_sum[1] <= r_rw - w_full;
            r_sum[2] <= w_half + r_rw - r_px;
        end
        if (i_ctrl.err_en) begin
            for (int j = 0; j < NWHEEL; j++) begin
                r_err[j] <= n_err[j];
            end
        end
    end

    assign o_err = r_err;

endmodule

`default_nettype wire

// ===== hdl/owp_lane.sv =====
// one wheel lane: incremental pi, saturation, direction and magnitude
`timescale 1ns / 1ps
`default_nettype none

module owp_lane (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  owp_pkg::t_lane_ctrl          i_ctrl,
    input  wire [owp_pkg::GAIN_W-1:0]    i_kp,
    input  wire [owp_pkg::GAIN_W-1:0]    i_ki,
    input  wire [owp_pkg::DUTY_W-1:0]    i_lim,
    input  owp_pkg::t_err                i_err,
    output logic                         o_dir,
    output owp_pkg::t_duty               o_duty
);
    import owp_pkg::*;

    localparam int D_W   = ERR_W + 1;
    localparam int PD_W  = GAIN_W + 1 + D_W;
    localparam int IE_W  = GAIN_W + 1 + ERR_W;
    localparam int SUM_W2 = PD_W + 2;
    localparam int V_W   = ACC_W - 8;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    t_err                      r_prev;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PD_W-1:0]    r_pd;
    logic signed [IE_W-1:0]    r_ie;
    logic                      r_dir;
    t_duty                     r_duty;

    logic signed [GAIN_W:0]    w_kp_s, w_ki_s;
    logic signed [D_W-1:0]     w_d;
    logic signed [SUM_W2-1:0]  w_sum;
    logic signed [ACC_W-1:0]   n_acc;
    logic                      n_dir;
    t_duty                     n_duty;

    assign w_kp_s = $signed({1'b0, i_kp});
    assign w_ki_s = $signed({1'b0, i_ki});
    assign w_d    = D_W'(i_err) - D_W'(r_prev);
    assign w_sum  = SUM_W2'(r_acc) + SUM_W2'(r_pd) + SUM_W2'(r_ie);

    // clamp the exact sum to the 32 bit range
    always_comb begin
        if (w_sum[SUM_W2-1:ACC_W-1] == '0 || w_sum[SUM_W2-1:ACC_W-1] == '1) begin
            n_acc = w_sum[ACC_W-1:0];
        end else if (w_sum[SUM_W2-1]) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = ACC_MAX;
        end
    end

    always_comb begin
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] lim_s;
        logic                  up;
        up    = r_acc[ACC_W-1] && (r_acc[7:0] != '0);
        v     = $signed(r_acc[ACC_W-1:8]) + $signed({{(V_W-1){1'b0}}, up});
        lim_s = $signed({{(V_W-DUTY_W){1'b0}}, i_lim});
        if (v > lim_s) begin
            v = lim_s;
        end else if (v < -lim_s) begin
            v = -lim_s;
        end
        n_dir = (v > 0);
        if (v < 0) begin
            n_duty = DUTY_W'(-v);
        end else begin
            n_duty = DUTY_W'(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_acc  <= '0;
        end else if (i_ctrl.acc_en) begin
            r_prev <= i_err;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_pd <= PD_W'(w_kp_s) * PD_W'(w_d);
            r_ie <= IE_W'(w_ki_s) * IE_W'(i_err);
        end
        if (i_ctrl.drv_en) begin
            r_dir  <= n_dir;
            r_duty <= n_duty;
        end
    end

    assign o_dir  = r_dir;
    assign o_duty = r_duty;

endmodule

`default_nettype wire

// ===== hdl/owp_merge.sv =====
// output register that gathers the three lane results
`timescale 1ns / 1ps
`default_nettype none

module owp_merge (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  wire                  i_ready,
    input  wire                  i_dir  [owp_pkg::NWHEEL],
    input  owp_pkg::t_duty       i_duty [owp_pkg::NWHEEL],
    output logic                 o_valid,
    output logic                 o_dir_a,
    output owp_pkg::t_duty       o_duty_a,
    output logic                 o_dir_b,
    output owp_pkg::t_duty       o_duty_b,
    output logic                 o_dir_c,
    output owp_pkg::t_duty       o_duty_c
);
    import owp_pkg::*;

    logic  r_valid;
    logic  r_dir  [NWHEEL];
    t_duty r_duty [NWHEEL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < NWHEEL; j++) begin
                r_dir[j]  <= i_dir[j];
                r_duty[j] <= i_duty[j];
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_dir_a  = r_dir[0];
    assign o_duty_a = r_duty[0];
    assign o_dir_b  = r_dir[1];
    assign o_duty_b = r_duty[1];
    assign o_dir_c  = r_dir[2];
    assign o_duty_c = r_duty[2];

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_pi_speed_control.sv =====
// Three wheel omni speed controller. Each request is one control period: body
// velocity (vx, vy, w) and the three measured wheel speeds. The kinematics unit
// forms the three wheel targets and errors, three pi lanes update their
// accumulators side by side, and the output register gathers direction and
// duty for all three wheels. One request is in flight at a time; after acceptance
// the sequencer walks the multiply, sum, error, pi multiply, accumulate, drive and
// output load steps in order, and it returns to idle before a new request is taken.
// A new request is taken as soon as the previous result has entered the output
// register, even while that result is still waiting to be taken; a result that
// finds the output register full holds the sequencer until it drains. kp, ki and
// pwm_limit are written through the config port; the user must write them only
// while idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_pi_speed_control (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [owp_pkg::IDX_W-1:0]          i_cfg_idx,
    input  wire [owp_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire signed [owp_pkg::IN_W-1:0]    i_vx,
    input  wire signed [owp_pkg::IN_W-1:0]    i_vy,
    input  wire signed [owp_pkg::IN_W-1:0]    i_w,
    input  wire signed [owp_pkg::IN_W-1:0]    i_enc_a,
    input  wire signed [owp_pkg::IN_W-1:0]    i_enc_b,
    input  wire signed [owp_pkg::IN_W-1:0]    i_enc_c,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_dir_a,
    output owp_pkg::t_duty                    o_duty_a,
    output logic                              o_dir_b,
    output owp_pkg::t_duty                    o_duty_b,
    output logic                              o_dir_c,
    output owp_pkg::t_duty                    o_duty_c
);
    import owp_pkg::*;

    t_state                r_state, n_state;
    logic [GAIN_W-1:0]     r_kp, r_ki;
    logic [DUTY_W-1:0]     r_lim;
    logic [DUTY_W-1:0]     w_lim;

    t_kin_ctrl             w_kin_ctrl;
    t_lane_ctrl            w_lane_ctrl;
    logic                  w_load_out;
    t_err                  w_err  [NWHEEL];
    logic                  w_dir  [NWHEEL];
    t_duty                 w_duty [NWHEEL];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= '0;
            r_ki  <= '0;
            r_lim <= LIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:  r_kp  <= i_cfg_data;
                CFG_KI:  r_ki  <= i_cfg_data;
                CFG_LIM: r_lim <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_lim = (r_lim > FULL_SCALE) ? FULL_SCALE : r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_kin_ctrl  = '0;
        w_lane_ctrl = '0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                w_kin_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_KMUL;
                end
            end
            ST_KMUL: begin
                w_kin_ctrl.mul_en = 1'b1;
                n_state = ST_KSUM;
            end
            ST_KSUM: begin
                w_kin_ctrl.sum_en = 1'b1;
                n_state = ST_ERR;
            end
            ST_ERR: begin
                w_kin_ctrl.err_en = 1'b1;
                n_state = ST_PMUL;
            end
            ST_PMUL: begin
                w_lane_ctrl.mul_en = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                w_lane_ctrl.acc_en = 1'b1;
                n_state = ST_DRV;
            end
            ST_DRV: begin
                w_lane_ctrl.drv_en = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait for room in the output register
                if (!o_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    owp_kin u_kin (
        .i_clk   (i_clk),
        .i_ctrl  (w_kin_ctrl),
        .i_vx    (i_vx),
        .i_vy    (i_vy),
        .i_w     (i_w),
        .i_enc_a (i_enc_a),
        .i_enc_b (i_enc_b),
        .i_enc_c (i_enc_c),
        .o_err   (w_err)
    );

    for (genvar g = 0; g < NWHEEL; g++) begin : g_lane
        owp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_lane_ctrl),
            .i_kp    (r_kp),
            .i_ki    (r_ki),
            .i_lim   (w_lim),
            .i_err   (w_err[g]),
            .o_dir   (w_dir[g]),
            .o_duty  (w_duty[g])
        );
    end

    owp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load_out),
        .i_ready  (i_out_ready),
        .i_dir    (w_dir),
        .i_duty   (w_duty),
        .o_valid  (o_out_valid),
        .o_dir_a  (o_dir_a),
        .o_duty_a (o_duty_a),
        .o_dir_b  (o_dir_b),
        .o_duty_b (o_duty_b),
        .o_dir_c  (o_dir_c),
        .o_duty_c (o_duty_c)
    );

endmodule

`default_nettype wire

// ===== hdl/owp_checker.sv =====
// port level checks for the omni wheel speed controller and their bind
`timescale 1ns / 1ps
`default_nettype none

module owp_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_ready,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire                          o_dir_a,
    input wire [owp_pkg::DUTY_W-1:0]    o_duty_a,
    input wire                          o_dir_b,
    input wire [owp_pkg::DUTY_W-1:0]    o_duty_b,
    input wire                          o_dir_c,
    input wire [owp_pkg::DUTY_W-1:0]    o_duty_c
);
    import owp_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one request in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_duty_a)
            && $stable(o_duty_b) && $stable(o_duty_c))
        else $error("stalled result changed");

    // duty never above full scale
    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_duty_a <= FULL_SCALE && o_duty_b <= FULL_SCALE
            && o_duty_c <= FULL_SCALE)
        else $error("duty above full scale");

    // forward direction implies nonzero drive
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_dir_a || o_duty_a != '0) && (!o_dir_b || o_duty_b != '0)
            && (!o_dir_c || o_duty_c != '0))
        else $error("direction set with zero duty");

endmodule

bind omni_wheel_pi_speed_control owp_checker u_owp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_dir_a     (o_dir_a),
    .o_duty_a    (o_duty_a),
    .o_dir_b     (o_dir_b),
    .o_duty_b    (o_duty_b),
    .o_dir_c     (o_dir_c),
    .o_duty_c    (o_duty_c)
);

`default_nettype wire
